// ===== rtl/core/lkx_pkg.sv =====
// ---------------------------------------------------------------------------
// lkx_pkg: shared definitions for the keyed XOR stream cipher
// Key length, LCG constants, stage records and the key character helpers.
// ---------------------------------------------------------------------------
package lkx_pkg;

   // Key geometry
   localparam int KEY_LENGTH = 32;
   localparam int POS_W      = (KEY_LENGTH > 1) ? $clog2(KEY_LENGTH) : 1;
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(KEY_LENGTH - 1);

   // Generator: state = state * LCG_MUL + LCG_ADD (mod 2^32), output bits 30..16
   localparam logic [31:0] LCG_MUL = 32'd214013;
   localparam logic [31:0] LCG_ADD = 32'd2531011;
   localparam int RAND_W = 15;

   // Alphabet: a-z, A-Z, 1-9
   localparam logic [7:0] ALPHA_SIZE = 8'd61;

   // Register file
   localparam int CSR_ADDR_W = 3;
   localparam logic CSR_IDX_SEED = 1'b0;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       start_message;
   } msg_req_type;

   typedef struct packed {
      logic [7:0]        data_byte;
      logic              use_store;
      logic [POS_W-1:0]  key_pos;
      logic [RAND_W-1:0] rand_val;
   } key_req_type;

   // r mod 61 by folding: 64 is 3 mod 61, so fold the upper digits down twice,
   // then at most two subtractions remain.
   function automatic logic [5:0] rand_mod61(input logic [RAND_W-1:0] r);
      logic [10:0] fold_a;
      logic [7:0]  fold_b;
      logic [7:0]  rem;
      fold_a = {2'b00, r[14:6]} + {1'b0, r[14:6], 1'b0} + {5'b00000, r[5:0]};
      fold_b = {3'b000, fold_a[10:6]} + {2'b00, fold_a[10:6], 1'b0}
             + {2'b00, fold_a[5:0]};
      if (fold_b >= 8'(2 * ALPHA_SIZE)) begin
         rem = fold_b - 8'(2 * ALPHA_SIZE);
      end else if (fold_b >= ALPHA_SIZE) begin
         rem = fold_b - ALPHA_SIZE;
      end else begin
         rem = fold_b;
      end
      return rem[5:0];
   endfunction

   // Map an index 0..60 to its ASCII character
   function automatic logic [6:0] key_alphabet(input logic [5:0] idx);
      logic [6:0] ch;
      if (idx < 6'd26) begin
         ch = 7'd97 + {1'b0, idx};
      end else if (idx < 6'd52) begin
         ch = 7'd39 + {1'b0, idx};
      end else begin
         ch = {1'b0, idx} - 7'd3;
      end
      return ch;
   endfunction

endpackage

// ===== rtl/core/lkx_csr.sv =====
// ---------------------------------------------------------------------------
// lkx_csr: configuration registers
// APB-style slave holding the seed register; always ready.
// ---------------------------------------------------------------------------
module lkx_csr import lkx_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready,
   output logic [31:0]           seed_value
);

   logic [31:0] seed_ff, seed_in;
   logic        wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_comb begin
      seed_in = seed_ff;
      if (wr_en && (paddr[CSR_ADDR_W-1] == CSR_IDX_SEED)) begin
         seed_in = pwdata;
      end
   end

   always_comb begin
      case (paddr[CSR_ADDR_W-1])
         CSR_IDX_SEED: prdata = seed_ff;
         default:      prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= '0;
      end else begin
         seed_ff <= seed_in;
      end
   end

   assign seed_value = seed_ff;

endmodule

// ===== rtl/core/lkx_keygen.sv =====
// ---------------------------------------------------------------------------
// lkx_keygen: generator stage
// Tracks the LCG state, key position and key-complete flag; advances the LCG
// once per request while the key is still being built.
// ---------------------------------------------------------------------------
module lkx_keygen import lkx_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic [31:0] seed_value,
   input  logic        in_valid,
   input  msg_req_type in_req,
   output logic        in_ready,
   output logic        out_valid,
   output key_req_type out_req,
   input  logic        out_ready
);

   logic [31:0]       lcg_ff, lcg_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic              complete_ff, complete_in;
   logic              valid_ff, valid_in;
   key_req_type       req_ff, req_in;

   logic              take;
   logic [31:0]       cur_lcg;
   logic [31:0]       new_lcg;
   logic [POS_W-1:0]  cur_pos;
   logic              cur_complete;

   assign in_ready = !valid_ff || out_ready;
   assign take     = in_valid && in_ready;

   always_comb begin
      // a start reloads the seed and restarts the key
      cur_lcg      = in_req.start_message ? seed_value : lcg_ff;
      cur_pos      = in_req.start_message ? '0 : pos_ff;
      cur_complete = in_req.start_message ? 1'b0 : complete_ff;
      new_lcg      = cur_lcg * LCG_MUL + LCG_ADD;

      lcg_in      = lcg_ff;
      pos_in      = pos_ff;
      complete_in = complete_ff;
      req_in      = req_ff;
      valid_in    = out_ready ? 1'b0 : valid_ff;

      if (take) begin
         valid_in          = 1'b1;
         req_in.data_byte  = in_req.data_byte;
         req_in.use_store  = cur_complete;
         req_in.key_pos    = cur_pos;
         req_in.rand_val   = new_lcg[30:16];
         if (!cur_complete) begin
            lcg_in = new_lcg;
         end
         if (cur_pos == POS_LAST) begin
            pos_in      = '0;
            complete_in = 1'b1;
         end else begin
            pos_in      = cur_pos + POS_W'(1);
            complete_in = cur_complete;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lcg_ff      <= '0;
         pos_ff      <= '0;
         complete_ff <= 1'b0;
         valid_ff    <= 1'b0;
      end else begin
         lcg_ff      <= lcg_in;
         pos_ff      <= pos_in;
         complete_ff <= complete_in;
         valid_ff    <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
   end

   assign out_valid = valid_ff;
   assign out_req   = req_ff;

endmodule

// ===== rtl/core/lkx_keyout.sv =====
// ---------------------------------------------------------------------------
// lkx_keyout: key character and result stage
// Maps the random value to a character or reads the stored key, records
// fresh characters, and holds the result register.
// ---------------------------------------------------------------------------
module lkx_keyout import lkx_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        stage_valid,
   input  key_req_type stage_req,
   output logic        stage_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_cipher_byte,
   output logic [6:0]  rsp_key_char
);

   logic [6:0] key_store_ff [KEY_LENGTH];
   logic       valid_ff, valid_in;
   logic [7:0] cipher_ff, cipher_in;
   logic [6:0] char_ff, char_in;

   logic       take;
   logic [6:0] gen_char;

   assign stage_ready = !valid_ff || rsp_ready;
   assign take        = stage_valid && stage_ready;

   always_comb begin
      gen_char  = key_alphabet(rand_mod61(stage_req.rand_val));
      char_in   = char_ff;
      cipher_in = cipher_ff;
      valid_in  = rsp_ready ? 1'b0 : valid_ff;
      if (take) begin
         valid_in  = 1'b1;
         char_in   = stage_req.use_store ? key_store_ff[stage_req.key_pos] : gen_char;
         cipher_in = stage_req.data_byte ^ {1'b0, char_in};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // record each new character while the key is being built
   always_ff @(posedge clock) begin
      cipher_ff <= cipher_in;
      char_ff   <= char_in;
      if (take && !stage_req.use_store) begin
         key_store_ff[stage_req.key_pos] <= gen_char;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_cipher_byte = cipher_ff;
   assign rsp_key_char    = char_ff;

endmodule

// ===== rtl/core/lcg_keyed_xor_stream_cipher.sv =====
// ---------------------------------------------------------------------------
// lcg_keyed_xor_stream_cipher: keyed repeating-XOR byte cipher
// XORs each byte with a 32-character key drawn from a seeded LCG.
// ---------------------------------------------------------------------------
// Usage
//   Request channel (req_valid/req_ready): one byte plus a start flag. Set
//   req_start_message on the first byte of a message to reload the LCG from
//   the seed register and restart the key at position 0.
//   Response channel (rsp_valid/rsp_ready): one result per request, in order:
//   the transformed byte and the key character used for it. Encryption and
//   decryption are the same operation.
//   Configuration: APB-style port, seed register at byte address 0. Write it
//   only while the block is idle; it takes effect at the next start.
// Timing
//   An accepted request passes through the input register, generator stage
//   (LCG multiply-add) and result register (mod-61 fold, key character,
//   XOR) to rsp_valid. One request per cycle sustained while rsp_ready is
//   high; the LCG recurrence closes within the generator stage.
// Reset and stalls
//   Reset empties the pipeline, clears the LCG state, key position and the
//   key-complete flag; the seed resets to 0. While rsp_ready is low the three
//   stages fill and then req_ready drops; no request is lost or repeated.
// ---------------------------------------------------------------------------
module lcg_keyed_xor_stream_cipher import lkx_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_data_byte,
   input  logic                  req_start_message,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [7:0]            rsp_cipher_byte,
   output logic [6:0]            rsp_key_char,
   // configuration port
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   logic [31:0]  seed_value;

   // input register
   logic         in_valid_ff, in_valid_in;
   msg_req_type  in_req_ff, in_req_in;
   logic         req_take;

   // generator to result stage
   logic         kg_in_ready;
   logic         kg_valid;
   key_req_type  kg_req;
   logic         ko_ready;

   lkx_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .seed_value (seed_value)
   );

   // take a new request whenever the input register empties this cycle
   assign req_ready = !reset && (!in_valid_ff || kg_in_ready);
   assign req_take  = req_valid && req_ready;

   always_comb begin
      in_req_in   = in_req_ff;
      in_valid_in = kg_in_ready ? 1'b0 : in_valid_ff;
      if (req_take) begin
         in_valid_in             = 1'b1;
         in_req_in.data_byte     = req_data_byte;
         in_req_in.start_message = req_start_message;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // hold the payload; no reset needed
   always_ff @(posedge clock) begin
      in_req_ff <= in_req_in;
   end

   lkx_keygen u_keygen (
      .clock      (clock),
      .reset      (reset),
      .seed_value (seed_value),
      .in_valid   (in_valid_ff),
      .in_req     (in_req_ff),
      .in_ready   (kg_in_ready),
      .out_valid  (kg_valid),
      .out_req    (kg_req),
      .out_ready  (ko_ready)
   );

   lkx_keyout u_keyout (
      .clock           (clock),
      .reset           (reset),
      .stage_valid     (kg_valid),
      .stage_req       (kg_req),
      .stage_ready     (ko_ready),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_cipher_byte (rsp_cipher_byte),
      .rsp_key_char    (rsp_key_char)
   );

endmodule

// ===== rtl/core/lkx_checker.sv =====
// ---------------------------------------------------------------------------
// lkx_checker: port-level checks for the stream cipher
// Watches the top-level ports for latency, key alphabet and stall behavior.
// ---------------------------------------------------------------------------
module lkx_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [7:0]            rsp_cipher_byte,
   input logic [6:0]            rsp_key_char
);

   // empty pipeline right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a response that rises must match an earlier accepted request
   a_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 3))
      else $error("response without matching request");

   // every key character is from a-z, A-Z or 1-9
   a_key_alphabet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_key_char >= 7'd97 && rsp_key_char <= 7'd122) ||
                     (rsp_key_char >= 7'd65 && rsp_key_char <= 7'd90) ||
                     (rsp_key_char >= 7'd49 && rsp_key_char <= 7'd57)))
      else $error("key character outside the alphabet");

   // stalled response holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_cipher_byte) && $stable(rsp_key_char))
      else $error("stalled response changed");

endmodule

bind lcg_keyed_xor_stream_cipher lkx_checker u_lkx_checker (.*);
